// File: hw/rtl/pdl_pkg.sv
// ----------------------------------------------------------------------------
// pdl_pkg: shared constants for the pd loop with pdm modulator
// field widths, reset values and command codes
// ----------------------------------------------------------------------------
package pdl_pkg;

    // default full scale of the drive level and the modulator
    localparam int unsigned FULL_SCALE_DEF = 2048;

    // converter sample and target width
    localparam int SAMPLE_W = 10;
    localparam logic [SAMPLE_W-1:0] TARGET_RESET = 10'd512;

    // previous sample holds one sign bit above the converter width
    localparam int PREV_W = SAMPLE_W + 1;
    localparam logic signed [PREV_W-1:0] PREV_RESET = -11'sd1;

    // differences of two samples, and the derivative gain shift (x256)
    localparam int DIFF_W = SAMPLE_W + 2;
    localparam int DERIV_SHIFT = 8;
    localparam int DERIV_W = DIFF_W + DERIV_SHIFT;

    // command codes
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

endpackage

// File: hw/rtl/pdl_step.sv
// ----------------------------------------------------------------------------
// pdl_step: one modulator tick
// pd update of the drive level on a sample, then one sigma-delta step
// ----------------------------------------------------------------------------
module pdl_step #(
    parameter int unsigned FULL_SCALE = pdl_pkg::FULL_SCALE_DEF,
    localparam int DRIVE_W = $clog2(FULL_SCALE) + 2,
    localparam int ERR_W = $clog2(FULL_SCALE) + 3
) (
    input  logic                               command,
    input  logic [pdl_pkg::SAMPLE_W-1:0]       adc_sample,
    input  logic [pdl_pkg::SAMPLE_W-1:0]       target_level,
    input  logic signed [DRIVE_W-1:0]          drive_level,
    input  logic signed [pdl_pkg::PREV_W-1:0]  prev_sample,
    input  logic signed [ERR_W-1:0]            err_acc,
    output logic signed [DRIVE_W-1:0]          drive_new,
    output logic signed [pdl_pkg::PREV_W-1:0]  prev_new,
    output logic signed [ERR_W-1:0]            err_new,
    output logic                               pdm_bit
);

    localparam int SUM_W =
        ((DRIVE_W > pdl_pkg::DERIV_W) ? DRIVE_W : pdl_pkg::DERIV_W) + 2;
    localparam int ERR_X_W = ERR_W + 1;
    localparam logic signed [SUM_W-1:0] FS_SUM = SUM_W'(FULL_SCALE);
    localparam logic signed [ERR_X_W-1:0] FS_ERR = ERR_X_W'(FULL_SCALE);

    logic signed [pdl_pkg::DIFF_W-1:0]  diff_p;
    logic signed [pdl_pkg::DIFF_W-1:0]  diff_p_adj;
    logic signed [pdl_pkg::DIFF_W-1:0]  prop;
    logic signed [pdl_pkg::DIFF_W-1:0]  diff_d;
    logic signed [pdl_pkg::DERIV_W-1:0] deriv;
    logic signed [SUM_W-1:0]            sum;
    logic signed [DRIVE_W-1:0]          drive_clamped;
    logic signed [ERR_X_W-1:0]          drive_x;
    logic signed [ERR_X_W-1:0]          err_x;
    logic signed [ERR_X_W-1:0]          err_sum;

    // proportional term, halved with truncation toward zero
    assign diff_p     = signed'({2'b00, adc_sample}) - signed'({2'b00, target_level});
    assign diff_p_adj = diff_p + pdl_pkg::DIFF_W'(diff_p[pdl_pkg::DIFF_W-1]);
    assign prop       = diff_p_adj >>> 1;

    // derivative term, 256 times the sample step
    assign diff_d = signed'({2'b00, adc_sample}) - pdl_pkg::DIFF_W'(prev_sample);
    assign deriv  = {diff_d, {pdl_pkg::DERIV_SHIFT{1'b0}}};

    assign sum = SUM_W'(drive_level) - SUM_W'(prop) - SUM_W'(deriv);

    always_comb
    begin
        if (sum > FS_SUM)
        begin
            drive_clamped = DRIVE_W'(FS_SUM);
        end
        else if (sum < -FS_SUM)
        begin
            drive_clamped = DRIVE_W'(-FS_SUM);
        end
        else
        begin
            drive_clamped = DRIVE_W'(sum);
        end
    end

    assign drive_new = (command == pdl_pkg::CMD_SAMPLE) ? drive_clamped : drive_level;
    assign prev_new  = (command == pdl_pkg::CMD_SAMPLE) ?
                       signed'({1'b0, adc_sample}) : prev_sample;

    // first-order sigma-delta on the updated drive level
    assign drive_x = ERR_X_W'(drive_new);
    assign err_x   = ERR_X_W'(err_acc);
    assign pdm_bit = (drive_x >= err_x);
    assign err_sum = err_x + (pdm_bit ? FS_ERR : -FS_ERR) - drive_x;
    assign err_new = err_sum[ERR_W-1:0];

endmodule

// File: hw/rtl/pd_loop_with_pdm_modulator.sv
// ----------------------------------------------------------------------------
// pd_loop_with_pdm_modulator: pd-controlled drive level feeding a pdm
// first-order sigma-delta modulator with a pd correction on each sample word
// ----------------------------------------------------------------------------
// flow: an accepted word passes the input register, then the result register, which raises out_valid
// throughput: one word per cycle while out_stall does not hold the result register, set by the state update loop
// reset: drive 0, previous sample -1, error 0, target 512, pipeline empty
// configuration is always ready and takes effect on the next sample
// ----------------------------------------------------------------------------
module pd_loop_with_pdm_modulator #(
    parameter int unsigned FULL_SCALE = pdl_pkg::FULL_SCALE_DEF,
    localparam int DRIVE_W = $clog2(FULL_SCALE) + 2,
    localparam int ERR_W = $clog2(FULL_SCALE) + 3
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration write channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [pdl_pkg::SAMPLE_W-1:0] cfg_data,
    // input word channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         command,
    input  logic [pdl_pkg::SAMPLE_W-1:0] adc_sample,
    // result word channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         pdm_bit,
    output logic signed [DRIVE_W-1:0]    drive_now
);

    // input register stage
    logic                         s1_valid_reg, s1_valid_next;
    logic                         s1_cmd_reg;
    logic [pdl_pkg::SAMPLE_W-1:0] s1_sample_reg;

    // result register stage
    logic                         out_valid_reg, out_valid_next;
    logic                         pdm_bit_reg;
    logic signed [DRIVE_W-1:0]    drive_now_reg;

    // loop state
    logic [pdl_pkg::SAMPLE_W-1:0]      target_level_reg;
    logic signed [DRIVE_W-1:0]         drive_level_reg, drive_level_next;
    logic signed [pdl_pkg::PREV_W-1:0] prev_sample_reg, prev_sample_next;
    logic signed [ERR_W-1:0]           err_acc_reg, err_acc_next;
    logic                              pdm_bit_next;

    logic in_accept;
    logic out_free;
    logic advance;

    // result register can take a word when empty or being drained
    assign out_free  = !out_valid_reg || !out_stall;
    // the word in the input register moves on and commits its state update
    assign advance   = s1_valid_reg && out_free;
    // input register frees up in the same cycle it advances
    assign in_stall  = s1_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    pdl_step #(
        .FULL_SCALE (FULL_SCALE)
    ) u_step (
        .command      (s1_cmd_reg),
        .adc_sample   (s1_sample_reg),
        .target_level (target_level_reg),
        .drive_level  (drive_level_reg),
        .prev_sample  (prev_sample_reg),
        .err_acc      (err_acc_reg),
        .drive_new    (drive_level_next),
        .prev_new     (prev_sample_next),
        .err_new      (err_acc_next),
        .pdm_bit      (pdm_bit_next)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    assign out_valid_next = out_free ? s1_valid_reg : out_valid_reg;

    // control and loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            target_level_reg <= pdl_pkg::TARGET_RESET;
            drive_level_reg  <= '0;
            prev_sample_reg  <= pdl_pkg::PREV_RESET;
            err_acc_reg      <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                target_level_reg <= cfg_data;
            end
            // state only moves when a word is committed to the result register
            if (advance)
            begin
                drive_level_reg <= drive_level_next;
                prev_sample_reg <= prev_sample_next;
                err_acc_reg     <= err_acc_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_cmd_reg    <= command;
            s1_sample_reg <= adc_sample;
        end
        if (advance)
        begin
            pdm_bit_reg   <= pdm_bit_next;
            drive_now_reg <= drive_level_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign pdm_bit   = pdm_bit_reg;
    assign drive_now = drive_now_reg;

endmodule
